>>> src/qpe_pkg.sv
// ============================================================================
// qpe_pkg - quoted-printable encoder package
// Shared character codes, descriptor type and hex digit helper.
// ============================================================================
package qpe_pkg;

  // Character codes
  localparam logic [7:0] QPE_CHAR_EQ    = 8'h3D;
  localparam logic [7:0] QPE_CHAR_CR    = 8'h0D;
  localparam logic [7:0] QPE_CHAR_LF    = 8'h0A;
  localparam logic [7:0] QPE_CHAR_TAB   = 8'h09;
  localparam logic [7:0] QPE_CHAR_SPACE = 8'd32;
  localparam logic [7:0] QPE_CHAR_DEL   = 8'd127;
  localparam logic [3:0] QPE_NIBBLE     = 4'hF;

  // Configuration
  localparam logic [7:0] QPE_MAX_LINE_RESET = 8'd76;
  localparam int         QPE_ADDR_W         = 3;
  localparam logic       QPE_REG_MAX_LINE   = 1'b0;   // paddr[2] of register 0

  // Decoupling queue
  localparam int QPE_FIFO_DEPTH = 4;

  // Output sequencing: up to six bytes per item
  localparam int QPE_IDX_W = 3;

  // Line counter
  localparam int QPE_CNT_W = 9;

  typedef struct packed {
    logic       brk;    // soft break '=' CR LF ahead of the byte
    logic       esc;    // byte goes out as '=' and two hex digits
    logic [7:0] data;   // raw byte
  } qpe_desc_t;

  function automatic logic [7:0] qpe_hex_digit(input logic [3:0] v);
    logic [3:0] n;
    n = v & QPE_NIBBLE;
    if (n < 4'd10) begin
      return 8'h30 + {4'b0000, n};
    end else begin
      return 8'h41 + {4'b0000, n} - 8'd10;
    end
  endfunction

endpackage

>>> src/qpe_in_if.sv
// ============================================================================
// qpe_in_if - raw byte channel
// Valid/ready channel carrying one message byte and the message-start flag.
// ============================================================================
interface qpe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       message_start;

  modport source (output valid, output data_byte, output message_start, input ready);
  modport sink   (input valid, input data_byte, input message_start, output ready);
endinterface

>>> src/qpe_out_if.sv
// ============================================================================
// qpe_out_if - encoded byte channel
// Valid/ready channel carrying one encoded byte and the end-of-run marker.
// ============================================================================
interface qpe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

>>> src/qpe_front.sv
// ============================================================================
// qpe_front - classifier and line counter
// Accepts raw bytes, classifies them, tracks line length, decides soft breaks.
// ============================================================================
module qpe_front import qpe_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  qpe_in_if.sink      in_ch,
  input  logic [7:0]  max_line_length,
  input  logic        full,
  output logic        push,
  output qpe_desc_t   desc
);

  logic [QPE_CNT_W-1:0] line_count;
  logic [QPE_CNT_W-1:0] line_count_next;
  logic [QPE_CNT_W-1:0] base;
  logic [QPE_CNT_W-1:0] len;
  logic [QPE_CNT_W-1:0] sum;
  logic [7:0]           b;
  logic                 pass;
  logic                 is_lf;
  logic                 esc;
  logic                 brk;

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;

  always_comb begin
    pass  = (b != QPE_CHAR_EQ && b > QPE_CHAR_SPACE && b < QPE_CHAR_DEL) ||
            b == QPE_CHAR_SPACE || b == QPE_CHAR_TAB || b == QPE_CHAR_CR;
    is_lf = (b == QPE_CHAR_LF);
    esc   = !pass && !is_lf;
    len   = esc ? QPE_CNT_W'(3) : QPE_CNT_W'(1);
    base  = in_ch.message_start ? '0 : line_count;
    sum   = is_lf ? QPE_CNT_W'(1) : base + len;
    brk   = sum >= {1'b0, max_line_length};
    line_count_next = brk ? len : sum;
    desc.brk  = brk;
    desc.esc  = esc;
    desc.data = b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
    end else if (push) begin
      line_count <= line_count_next;
    end
  end

  // count stays below max, or at most 3 after a break, so within the 257 checked here
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    line_count <= QPE_CNT_W'(257))
    else $error("line count out of range");

  a_lf_restart: assert property (@(posedge clk) disable iff (rst)
    (push && is_lf && !brk) |=> line_count == QPE_CNT_W'(1))
    else $error("LF did not restart line count");

endmodule

>>> src/qpe_fifo.sv
// ============================================================================
// qpe_fifo - descriptor queue
// Small first-word-fall-through queue between classifier and emitter.
// ============================================================================
module qpe_fifo import qpe_pkg::*; #(
  parameter int Depth = QPE_FIFO_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  qpe_desc_t wr_data,
  output logic      full,
  input  logic      pop,
  output logic      valid,
  output qpe_desc_t rd_data
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  qpe_desc_t       mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_pop;

  assign full    = (count == CntW'(Depth));
  assign valid   = (count != '0);
  assign rd_data = mem[rd_ptr];
  assign do_pop  = pop && valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> src/qpe_back.sv
// ============================================================================
// qpe_back - byte emitter
// Walks each descriptor out as 1 to 6 bytes into a registered output stage.
// ============================================================================
module qpe_back import qpe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fifo_valid,
  input  qpe_desc_t desc,
  output logic      pop,
  qpe_out_if.source out_ch
);

  logic [QPE_IDX_W-1:0] idx;
  logic [QPE_IDX_W-1:0] idx_next;
  logic [QPE_IDX_W-1:0] k;
  logic [QPE_IDX_W-1:0] last_k;
  logic                 brk_phase;
  logic                 last;
  logic                 advance;
  logic [7:0]           sel_byte;
  logic                 out_valid;
  logic [7:0]           out_byte;
  logic                 last_of_run;

  assign advance = fifo_valid && (!out_valid || out_ch.ready);

  always_comb begin
    brk_phase = desc.brk && (idx < QPE_IDX_W'(3));
    k         = desc.brk ? idx - QPE_IDX_W'(3) : idx;
    last_k    = desc.esc ? QPE_IDX_W'(2) : '0;
    last      = !brk_phase && (k == last_k);
    sel_byte  = desc.data;
    if (brk_phase) begin
      priority if (idx == '0)             sel_byte = QPE_CHAR_EQ;
      else if (idx == QPE_IDX_W'(1))      sel_byte = QPE_CHAR_CR;
      else                                sel_byte = QPE_CHAR_LF;
    end else if (desc.esc) begin
      priority if (k == '0)               sel_byte = QPE_CHAR_EQ;
      else if (k == QPE_IDX_W'(1))        sel_byte = qpe_hex_digit(desc.data[7:4]);
      else                                sel_byte = qpe_hex_digit(desc.data[3:0]);
    end
    pop      = advance && last;
    idx_next = idx;
    if (advance) begin
      idx_next = last ? '0 : idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      idx <= idx_next;
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte    <= sel_byte;
      last_of_run <= last;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.out_byte    = out_byte;
  assign out_ch.last_of_run = last_of_run;

  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= QPE_IDX_W'(5))
    else $error("emit index out of range");

  a_pop_rewinds: assert property (@(posedge clk) disable iff (rst)
    pop |=> idx == '0)
    else $error("index not rewound after descriptor done");

  a_pop_marks_last: assert property (@(posedge clk) disable iff (rst)
    pop |=> (out_valid && last_of_run))
    else $error("final byte not flagged last_of_run");

endmodule

>>> src/quoted_printable_encoder_unit.sv
// ============================================================================
// quoted_printable_encoder_unit - quoted-printable encoder top level
// Encodes one raw byte per transaction into its quoted-printable byte run,
// inserting soft line breaks at the programmed line length.
// ============================================================================
//
//  Channel  Dir  Carries                          Completes when
//  -------  ---  -------------------------------  ---------------------------
//  in_ch    in   data_byte, message_start         in_ch.valid & in_ch.ready
//  out_ch   out  out_byte, last_of_run            out_ch.valid & out_ch.ready
//  APB      in   max_line_length at 0x0           psel & penable & pwrite
//
//  Flow: one encoded byte leaves per cycle while out_ch is ready; an input
//  transaction yields 1 (plain), 3 (escaped), 4 (plain + break) or 6
//  (escaped + break) bytes, moved by the emitter through its output register.
//  The first byte passes the descriptor queue and the emitter output register
//  before it is presented, and completes when out_ch.ready is high.
//  Reset (rst, synchronous): line count 0, queue empty, output idle,
//  max_line_length = 76.
//  Stalls: the descriptor queue lets input keep flowing while out_ch stalls,
//  until the queue fills.
// ============================================================================
module quoted_printable_encoder_unit import qpe_pkg::*; #(
  parameter int FifoDepth = QPE_FIFO_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  qpe_in_if.sink                in_ch,
  qpe_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [QPE_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [7:0] max_line_length;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_line_length <= QPE_MAX_LINE_RESET;
    end else if (cfg_wr && paddr[2] == QPE_REG_MAX_LINE) begin
      max_line_length <= pwdata[7:0];
    end
  end

  // read back; only word 0 decodes, low address bits ignored
  always_comb begin
    prdata = '0;
    if (paddr[2] == QPE_REG_MAX_LINE) begin
      prdata = {24'b0, max_line_length};
    end
  end

  // --------------------------------------------------------------------------
  // Front: classify byte, update line count, decide soft break
  // --------------------------------------------------------------------------
  logic      push;
  logic      full;
  qpe_desc_t front_desc;

  qpe_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_ch           (in_ch),
    .max_line_length (max_line_length),
    .full            (full),
    .push            (push),
    .desc            (front_desc)
  );

  // --------------------------------------------------------------------------
  // Descriptor queue: decouples input acceptance from byte emission
  // --------------------------------------------------------------------------
  logic      pop;
  logic      fifo_valid;
  qpe_desc_t back_desc;

  qpe_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (front_desc),
    .full    (full),
    .pop     (pop),
    .valid   (fifo_valid),
    .rd_data (back_desc)
  );

  // --------------------------------------------------------------------------
  // Back: expand descriptor into '=' CR LF and the encoded byte(s)
  // --------------------------------------------------------------------------
  qpe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .fifo_valid (fifo_valid),
    .desc       (back_desc),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
